>>> rtl/rlew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlew_pkg: shared types and constants of the word run encoder
// Holds the register codes, reset values, forbidden word patterns and the
// result bundle that travels from the encoder step to the output serializer.
// ----------------------------------------------------------------------------
package rlew_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ESCAPE_TAG   = 2'd0;
  localparam logic [1:0] CFG_MAX_RUN      = 2'd1;
  localparam logic [1:0] CFG_MIN_ENCODED  = 2'd2;

  // Register reset values.
  localparam logic [15:0] ESCAPE_TAG_RST  = 16'hABCD;
  localparam logic [12:0] MAX_RUN_RST     = 13'd100;
  localparam logic [12:0] MIN_ENCODED_RST = 13'd4;

  // Forbidden high bytes.
  localparam logic [15:0] FORBID_MASK = 16'hFF00;
  localparam logic [15:0] FORBID_A    = 16'hA700;
  localparam logic [15:0] FORBID_B    = 16'hA800;

  // One accepted word yields at most four result words.
  typedef struct packed {
    logic [3:0][15:0] words;
    logic [1:0]       last_idx;
    logic             last;
    logic             fault;
  } rlew_bundle_t;

endpackage

>>> rtl/rlew_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlew_if: word channels of the run encoder
// Input channel carries raw words, output channel carries encoded words.
// ----------------------------------------------------------------------------
interface rlew_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] in_word;
  logic        in_last;

  modport source (output valid, output in_word, output in_last, input ready);
  modport sink   (input valid, input in_word, input in_last, output ready);
endinterface

interface rlew_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_word;
  logic        out_last;
  logic        fault;

  modport source (output valid, output out_word, output out_last, output fault,
                  input ready);
  modport sink   (input valid, input out_word, input out_last, input fault,
                  output ready);
endinterface

>>> rtl/rlew_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlew_core: run tracking and result building
// Holds the configuration and run state, and for each accepted word builds
// the bundle of words that closing runs produce, combinationally.
// ----------------------------------------------------------------------------
module rlew_core import rlew_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         accept,
  input  logic [15:0]  word,
  input  logic         last,
  output logic         push,
  output rlew_bundle_t bundle
);

  typedef struct packed {
    logic [3:0][15:0] words;
    logic [1:0]       cnt;
  } rlew_seg_t;

  logic [15:0] escape_tag_r;
  logic [12:0] max_run_r;
  logic [12:0] min_encoded_r;
  logic [15:0] run_value_r, run_value_nxt;
  logic [12:0] run_len_r, run_len_nxt;
  logic        fault_r, fault_nxt;

  logic [12:0] cap;
  logic [2:0]  thr;
  logic        forbidden;
  logic        extend;
  logic [12:0] len_b;
  logic [15:0] val_b;
  rlew_seg_t   seg_a, seg_b;
  logic [1:0]  cnt_a, cnt_b;
  logic [2:0]  total;

  // Words that one closed run sends: a triple or its literal copies.
  function automatic rlew_seg_t build_seg(input logic [15:0] value,
                                          input logic [12:0] len,
                                          input logic [2:0]  threshold,
                                          input logic [15:0] tag);
    rlew_seg_t s;
    s.words = {value, value, value, value};
    s.cnt   = 2'd0;
    if (len != 13'd0) begin
      if (len >= {10'd0, threshold}) begin
        s.words[0] = tag;
        s.words[1] = {3'd0, len};
        s.words[2] = value;
        s.cnt      = 2'd3;
      end else begin
        s.cnt = len[1:0];
      end
    end
    return s;
  endfunction

  // Effective limits after saturation.
  always_comb begin
    cap = (max_run_r == 13'd0) ? 13'd1 : max_run_r;
    if (min_encoded_r < 13'd2) begin
      thr = 3'd2;
    end else if (min_encoded_r > 13'd4) begin
      thr = 3'd4;
    end else begin
      thr = min_encoded_r[2:0];
    end
  end

  // Fault check and run decision.
  assign forbidden = ((word & FORBID_MASK) == FORBID_A) ||
                     ((word & FORBID_MASK) == FORBID_B) || (word == escape_tag_r);
  assign fault_nxt = fault_r | (accept & forbidden);
  assign extend    = (run_len_r != 13'd0) && (word == run_value_r) && (run_len_r < cap);

  // The run that the last word closes.
  assign len_b = extend ? run_len_r + 13'd1 : 13'd1;
  assign val_b = extend ? run_value_r : word;

  always_comb begin
    seg_a = build_seg(run_value_r, run_len_r, thr, escape_tag_r);
    seg_b = build_seg(val_b, len_b, thr, escape_tag_r);
    cnt_a = extend ? 2'd0 : seg_a.cnt;
    cnt_b = last ? seg_b.cnt : 2'd0;
    total = {1'b0, cnt_a} + {1'b0, cnt_b};
  end

  // Bundle assembly: closed run first, then the flushed run.
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < 4; i++) begin
      k = 2'(i) - cnt_a;
      if (3'(i) < {1'b0, cnt_a}) begin
        bundle.words[i] = seg_a.words[i];
      end else begin
        bundle.words[i] = seg_b.words[k];
      end
    end
    bundle.last_idx = 2'(total - 3'd1);
    bundle.last     = last;
    bundle.fault    = fault_nxt;
  end

  assign push = accept && (total != 3'd0);

  // Next run state.
  always_comb begin
    run_value_nxt = run_value_r;
    run_len_nxt   = run_len_r;
    if (accept) begin
      if (extend) begin
        run_len_nxt = run_len_r + 13'd1;
      end else begin
        run_value_nxt = word;
        run_len_nxt   = 13'd1;
      end
      if (last) begin
        run_len_nxt = 13'd0;
      end
    end
  end

  // State and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_tag_r  <= ESCAPE_TAG_RST;
      max_run_r     <= MAX_RUN_RST;
      min_encoded_r <= MIN_ENCODED_RST;
      run_value_r   <= 16'd0;
      run_len_r     <= 13'd0;
      fault_r       <= 1'b0;
    end else begin
      run_value_r <= run_value_nxt;
      run_len_r   <= run_len_nxt;
      fault_r     <= fault_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ESCAPE_TAG:  escape_tag_r  <= cfg_data;
          CFG_MAX_RUN:     max_run_r     <= cfg_data[12:0];
          CFG_MIN_ENCODED: min_encoded_r <= cfg_data[12:0];
          default: ;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The fault flag never falls outside reset.
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |=> fault_r) else $error("fault flag cleared");

  // A last word leaves no run open.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (run_len_r == 13'd0)) else $error("run open after last");

  // A word that only lengthens the open run sends nothing.
  a_extend_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && extend && !last) |-> !push) else $error("result from growing run");
`endif

endmodule

>>> rtl/rlew_serial.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlew_serial: result bundle register and word serializer
// Holds one bundle of up to four words and hands them out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module rlew_serial import rlew_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  rlew_bundle_t bundle,
  output logic         take,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [15:0]  out_word,
  output logic         out_last,
  output logic         fault
);

  rlew_bundle_t bundle_r;
  logic         valid_r, valid_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic         at_end;

  assign at_end = (idx_r == bundle_r.last_idx);

  // The slot frees when empty or when its final word leaves now.
  assign take = !valid_r || (out_ready && at_end);

  assign out_valid = valid_r;
  assign out_word  = bundle_r.words[idx_r];
  assign out_last  = bundle_r.last && at_end;
  assign fault     = bundle_r.fault;

  // Index and occupancy.
  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (valid_r && out_ready) begin
      if (at_end) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (push) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (push) begin
      bundle_r <= bundle;
    end
  end

`ifndef NO_ASSERTIONS
  // A bundle only loads into a free slot.
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> take) else $error("bundle overwritten");

  // The read index stays inside the bundle.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (idx_r <= bundle_r.last_idx)) else $error("index past bundle");

  // A stalled word keeps its place in the bundle.
  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (idx_r == $past(idx_r))) else $error("index moved");
`endif

endmodule

>>> rtl/rlew_word_run_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlew_word_run_encoder: streaming 16-bit word run-length encoder
//
//   channel  direction  payload                      handshake
//   in_ch    sink       in_word[15:0], in_last       valid / ready
//   out_ch   source     out_word[15:0], out_last,    valid / ready
//                       fault
//   cfg_*    input      cfg_index[1:0], cfg_data     cfg_we, no wait
//
// A word is encoded in the cycle it is accepted; its results appear on the
// output the next cycle, one word per cycle while out_ready is high, up to
// four per input. Input accepts one word per cycle while the result slot is
// free or drains its final word in that cycle; a growing run fills no slot.
// Reset is synchronous, active low, and clears run state and fault flag.
// ----------------------------------------------------------------------------
module rlew_word_run_encoder import rlew_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  rlew_in_if.sink       in_ch,
  rlew_out_if.source    out_ch
);

  logic         accept;
  logic         push;
  logic         take;
  rlew_bundle_t bundle;

  assign in_ch.ready = take;
  assign accept      = in_ch.valid && take;

  // Run tracking and bundle building.
  rlew_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .word      (in_ch.in_word),
    .last      (in_ch.in_last),
    .push      (push),
    .bundle    (bundle)
  );

  // Result slot and word serializer.
  rlew_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bundle    (bundle),
    .take      (take),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.out_word),
    .out_last  (out_ch.out_last),
    .fault     (out_ch.fault)
  );

endmodule
